FILE: hdl/bb3_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the 3x3 RGB box blur.
// No dependencies; bb3_front, bb3_back and box_blur_3x3_rgb import this package.
package bb3_pkg;

  localparam int BB3_MAX_WIDTH  = 1024;
  localparam int BB3_MAX_HEIGHT = 1024;

  localparam int DIM_W = 11;
  localparam logic [DIM_W-1:0] WIDTH_RST  = 11'd800;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 11'd600;

  localparam logic [0:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [0:0] REG_FRAME_HEIGHT = 1'b1;

  // A nine-pixel channel sum is at most 2295, and 7282 / 2**16 is close
  // enough to one ninth over that range to give the truncated quotient.
  localparam int SUM_W = 12;
  localparam int RECIP_W = 13;
  localparam logic [RECIP_W-1:0] DIV9_RECIP = 13'd7282;
  localparam int DIV9_SHIFT = 16;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic has_up;
    logic has_mid;
    logic emit;
    logic use_left;
    logic use_new;
    logic last;
  } tap_ctl_t;

endpackage

FILE: hdl/bb3_in_if.sv
`timescale 1ns / 1ps
// Input channel of the box blur: valid/ready handshake with one pixel or drain tick.
// No dependencies.
interface bb3_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;

  modport source (output valid, kind, in_red, in_green, in_blue, input ready);
  modport sink (input valid, kind, in_red, in_green, in_blue, output ready);
endinterface

FILE: hdl/bb3_out_if.sv
`timescale 1ns / 1ps
// Result channel of the box blur: valid/ready handshake with one blurred pixel.
// No dependencies.
interface bb3_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       frame_end;

  modport source (output valid, out_red, out_green, out_blue, frame_end, input ready);
  modport sink (input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface

FILE: hdl/bb3_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data (read-first).
// No dependencies.
module bb3_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

FILE: hdl/bb3_queue.sv
`timescale 1ns / 1ps
// Small FIFO between the classifying front end and the filter back end.
// No dependencies.
module bb3_queue #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] head
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [AW-1:0]    wptr_r, wptr_nxt;
  logic [AW-1:0]    rptr_r, rptr_nxt;
  logic [NW-1:0]    count_r, count_nxt;

  assign full      = (count_r == NW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = slot_r[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push) begin
      wptr_nxt = (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + AW'(1);
    end
    if (pop) begin
      rptr_nxt = (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + AW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + NW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_data;
    end
  end
endmodule

FILE: hdl/bb3_front.sv
`timescale 1ns / 1ps
// Front end of the box blur: tracks the raster position, masks pixels and works out
// which neighborhood taps each item needs. Depends on bb3_pkg and bb3_in_if.
module bb3_front #(
  parameter int MAX_WIDTH  = bb3_pkg::BB3_MAX_WIDTH,
  parameter int MAX_HEIGHT = bb3_pkg::BB3_MAX_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [bb3_pkg::DIM_W-1:0]     frame_width,
  input  logic [bb3_pkg::DIM_W-1:0]     frame_height,
  bb3_in_if.sink                        in_ch,
  input  logic                          q_full,
  output logic                          push,
  output logic [$clog2(MAX_WIDTH)-1:0]  push_addr,
  output bb3_pkg::rgb_t                 push_px,
  output bb3_pkg::tap_ctl_t             push_ctl
);
  import bb3_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int CX = CW + 1;
  localparam int RW = $clog2(MAX_HEIGHT + 3);

  logic [CW-1:0] col_r, col_nxt, col_cur;
  logic [RW-1:0] row_r, row_nxt, row_inc, row_cur;
  logic [CX-1:0] w_x;
  logic [RW-1:0] h_x, h_p1;
  logic          col_wrap;
  logic          line_end;
  logic          emit_mid;
  logic          emit_edge;

  always_comb begin
    if (frame_width == '0) begin
      w_x = CX'(1);
    end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
      w_x = CX'(MAX_WIDTH);
    end else begin
      w_x = CX'(frame_width);
    end
    if (frame_height == '0) begin
      h_x = RW'(1);
    end else if (32'(frame_height) > 32'(MAX_HEIGHT)) begin
      h_x = RW'(MAX_HEIGHT);
    end else begin
      h_x = RW'(frame_height);
    end
  end

  assign h_p1     = h_x + RW'(1);
  assign col_wrap = (CX'(col_r) >= w_x);
  assign row_inc  = col_wrap ? row_r + RW'(1) : row_r;
  assign col_cur  = col_wrap ? '0 : col_r;
  assign row_cur  = (row_inc > h_p1) ? '0 : row_inc;
  assign line_end = ((CX'(col_cur) + CX'(1)) >= w_x);

  assign emit_mid  = (col_cur != '0) && (row_cur != '0);
  assign emit_edge = (col_cur == '0) && (row_cur > RW'(1));

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;
  assign push_addr   = col_cur;

  always_comb begin
    push_px = '0;
    if (!in_ch.kind && (row_cur < h_x)) begin
      push_px.red   = in_ch.in_red;
      push_px.green = in_ch.in_green;
      push_px.blue  = in_ch.in_blue;
    end
    push_ctl.has_up   = (row_cur > RW'(1));
    push_ctl.has_mid  = (row_cur != '0);
    push_ctl.emit     = emit_mid || emit_edge;
    push_ctl.use_new  = emit_mid;
    push_ctl.use_left = emit_mid ? (col_cur > CW'(1)) : (w_x >= CX'(2));
    push_ctl.last     = emit_edge && (row_cur == h_p1);
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (push) begin
      if (row_cur >= h_p1) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (line_end) begin
        col_nxt = '0;
        row_nxt = row_cur + RW'(1);
      end else begin
        col_nxt = col_cur + CW'(1);
        row_nxt = row_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end
endmodule

FILE: hdl/bb3_back.sv
`timescale 1ns / 1ps
// Back end of the box blur: line stores, column window, neighbourhood sums, divide
// by nine and the output register. Depends on bb3_pkg, bb3_ram and bb3_out_if.
module bb3_back #(
  parameter int MAX_WIDTH = bb3_pkg::BB3_MAX_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  logic [$clog2(MAX_WIDTH)-1:0]  q_addr,
  input  bb3_pkg::rgb_t                 q_px,
  input  bb3_pkg::tap_ctl_t             q_ctl,
  bb3_out_if.source                     out_ch
);
  import bb3_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int PW = SUM_W + RECIP_W;

  logic          s2_v_r;
  logic [CW-1:0] s2_addr_r;
  rgb_t          s2_px_r;
  tap_ctl_t      s2_ctl_r;
  logic          fwd_r;
  rgb_t          fwd_up_r;
  rgb_t          fwd_mid_r;
  rgb_t          win_r [6];

  logic [23:0]   up_rd, mid_rd;
  rgb_t          up, mid;
  rgb_t          tv [9];
  logic [SUM_W-1:0] sum_red, sum_green, sum_blue;

  logic             s3_v_r;
  logic [SUM_W-1:0] s3_red_r, s3_green_r, s3_blue_r;
  logic             s3_last_r;

  logic       out_v_r;
  rgb_t       out_px_r;
  logic       out_last_r;
  logic [PW-1:0] prod_red, prod_green, prod_blue;

  logic out_free, s3_go, s3_free, s2_fire;

  assign out_free = !out_v_r || out_ch.ready;
  assign s3_go    = s3_v_r && out_free;
  assign s3_free  = !s3_v_r || s3_go;
  assign s2_fire  = s2_v_r && (!s2_ctl_r.emit || s3_free);
  assign q_pop    = q_valid && (!s2_v_r || s2_fire);

  bb3_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (s2_fire),
    .waddr (s2_addr_r),
    .wdata (mid),
    .re    (q_pop),
    .raddr (q_addr),
    .rdata (up_rd)
  );

  bb3_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_middle (
    .clk   (clk),
    .we    (s2_fire),
    .waddr (s2_addr_r),
    .wdata (s2_px_r),
    .re    (q_pop),
    .raddr (q_addr),
    .rdata (mid_rd)
  );

  always_comb begin
    up  = '0;
    mid = '0;
    if (s2_ctl_r.has_up) begin
      up = fwd_r ? fwd_up_r : rgb_t'(up_rd);
    end
    if (s2_ctl_r.has_mid) begin
      mid = fwd_r ? fwd_mid_r : rgb_t'(mid_rd);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tv[i]     = s2_ctl_r.use_left ? win_r[i] : '0;
      tv[i + 3] = win_r[i + 3];
    end
    tv[6] = s2_ctl_r.use_new ? up : '0;
    tv[7] = s2_ctl_r.use_new ? mid : '0;
    tv[8] = s2_ctl_r.use_new ? s2_px_r : '0;
    sum_red   = '0;
    sum_green = '0;
    sum_blue  = '0;
    for (int i = 0; i < 9; i++) begin
      sum_red   = sum_red + SUM_W'(tv[i].red);
      sum_green = sum_green + SUM_W'(tv[i].green);
      sum_blue  = sum_blue + SUM_W'(tv[i].blue);
    end
  end

  assign prod_red   = PW'(s3_red_r) * PW'(DIV9_RECIP);
  assign prod_green = PW'(s3_green_r) * PW'(DIV9_RECIP);
  assign prod_blue  = PW'(s3_blue_r) * PW'(DIV9_RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      if (q_pop) begin
        s2_v_r <= 1'b1;
      end else if (s2_fire) begin
        s2_v_r <= 1'b0;
      end
      if (s2_fire) begin
        for (int i = 0; i < 3; i++) begin
          win_r[i] <= win_r[i + 3];
        end
        win_r[3] <= up;
        win_r[4] <= mid;
        win_r[5] <= s2_px_r;
      end
      if (s2_fire && s2_ctl_r.emit) begin
        s3_v_r <= 1'b1;
      end else if (s3_go) begin
        s3_v_r <= 1'b0;
      end
      if (s3_go) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s2_addr_r <= q_addr;
      s2_px_r   <= q_px;
      s2_ctl_r  <= q_ctl;
      fwd_r     <= s2_fire && (s2_addr_r == q_addr);
      fwd_up_r  <= mid;
      fwd_mid_r <= s2_px_r;
    end
    if (s2_fire && s2_ctl_r.emit) begin
      s3_red_r   <= sum_red;
      s3_green_r <= sum_green;
      s3_blue_r  <= sum_blue;
      s3_last_r  <= s2_ctl_r.last;
    end
    if (s3_go) begin
      out_px_r.red   <= prod_red[DIV9_SHIFT +: 8];
      out_px_r.green <= prod_green[DIV9_SHIFT +: 8];
      out_px_r.blue  <= prod_blue[DIV9_SHIFT +: 8];
      out_last_r     <= s3_last_r;
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.out_red   = out_px_r.red;
  assign out_ch.out_green = out_px_r.green;
  assign out_ch.out_blue  = out_px_r.blue;
  assign out_ch.frame_end = out_last_r;
endmodule

FILE: hdl/box_blur_3x3_rgb.sv
`timescale 1ns / 1ps
// Top level of the 3x3 RGB box blur: configuration registers, front end, queue, back end.
// Depends on bb3_pkg, bb3_in_if, bb3_out_if, bb3_front, bb3_queue and bb3_back.
//
// The source sends one frame in raster order on in_ch, followed by width+1 drain
// items (kind set), and each transfer is one pixel position. Every transfer past the
// first one of the second line gives one blurred pixel on out_ch, in raster order, with
// frame_end set on the last pixel of the frame; out-of-frame neighbors count as zero
// and each channel sum is divided by nine with truncation.
// Throughput is one item per cycle while out_ch does not stall. A result reaches the
// output register after the item that completes its neighborhood passes the queue,
// the line store read and the sums, and the divide.
// frame_width and frame_height are written over the APB port at byte addresses 0 and
// 4; the user must write them only while the block is idle, which the block does not
// enforce. A value of zero acts as one, and one above the maximum acts as the maximum.
// Reset returns the raster position and the column window to zero and the registers
// to 800 by 600; the line stores are not cleared and need no clearing pass.
// When out_ch stalls, the result holds in the output register, the stages behind it
// fill, and in_ch.ready drops once the two-entry queue is full.
module box_blur_3x3_rgb #(
  parameter int MAX_WIDTH  = bb3_pkg::BB3_MAX_WIDTH,
  parameter int MAX_HEIGHT = bb3_pkg::BB3_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst_n,
  bb3_in_if.sink      in_ch,
  bb3_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bb3_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int QW = CW + $bits(rgb_t) + $bits(tap_ctl_t);

  logic [DIM_W-1:0] width_r, height_r;
  logic [0:0]       reg_idx;
  logic             cfg_wr;

  logic          push, q_full, q_pop, q_valid;
  logic [CW-1:0] push_addr, q_addr;
  rgb_t          push_px, q_px;
  tap_ctl_t      push_ctl, q_ctl;
  logic [QW-1:0] q_head;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_FRAME_WIDTH:  width_r  <= pwdata[DIM_W-1:0];
        REG_FRAME_HEIGHT: height_r <= pwdata[DIM_W-1:0];
        default:          width_r  <= width_r;
      endcase
    end
  end

  assign prdata = (reg_idx == REG_FRAME_HEIGHT) ? 32'(height_r) : 32'(width_r);

  bb3_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .frame_width  (width_r),
    .frame_height (height_r),
    .in_ch        (in_ch),
    .q_full       (q_full),
    .push         (push),
    .push_addr    (push_addr),
    .push_px      (push_px),
    .push_ctl     (push_ctl)
  );

  bb3_queue #(.WIDTH(QW), .DEPTH(2)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_addr, push_px, push_ctl}),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  assign {q_addr, q_px, q_ctl} = q_head;

  bb3_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_addr  (q_addr),
    .q_px    (q_px),
    .q_ctl   (q_ctl),
    .out_ch  (out_ch)
  );
endmodule
